@@ hdl/dcs_pkg.sv @@
// shared constants and defaults for the discrete cdf sampler
`default_nettype none

package dcs_pkg;

  // default storage shape
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_WEIGHT_BITS = 16;

  // fixed port widths
  localparam int ENTRY_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int RESULT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

`default_nettype wire

@@ hdl/discrete_cdf_sampler.sv @@
// top level: discrete inverse-cdf sampler with bisection over a prefix-sum memory
//
//  channel   direction  ports                                             transaction
//  command   in         start, busy, operation, entry_index, weight,     start & !busy
//                       random_fraction
//  result    out        done, sampled_index                               done (one cycle)
//  config    in         cfg_write, entries_in_use                         cfg_write
//
//  a weight write leaves busy low
//  a sample keeps busy high through the 32x16 partial-product multiply and one
//    prefix-sum memory read per bisection step; done is high in the first cycle with busy low
//  after weight or config changes, the first sample first rebuilds the prefix sums,
//    one weight memory read per entry
//  after reset a clearing pass zeroes the weight memory, busy high
//  results cannot be stalled: done is a one-cycle strobe
`default_nettype none

module discrete_cdf_sampler #(
  parameter int TABLE_DEPTH = dcs_pkg::DEF_TABLE_DEPTH,
  parameter int WEIGHT_BITS = dcs_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation,
  input  wire logic [dcs_pkg::ENTRY_W-1:0]   entry_index,
  input  wire logic [dcs_pkg::WEIGHT_W-1:0]  weight,
  input  wire logic [dcs_pkg::FRAC_W-1:0]    random_fraction,
  // result channel
  output logic                               done,
  output logic [dcs_pkg::RESULT_W-1:0]       sampled_index,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [dcs_pkg::COUNT_W-1:0]   entries_in_use
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  // prefix sums never exceed TABLE_DEPTH full-scale weights
  localparam int CUM_W   = WEIGHT_BITS + IDX_W;
  // total is multiplied 16 bits at a time
  localparam int CHUNKS  = (CUM_W + 15) / 16;
  localparam int TOT_PAD = CHUNKS * 16;
  localparam int PROD_W  = dcs_pkg::FRAC_W + TOT_PAD;
  localparam int KW      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,   // zero the weight memory after reset
    ST_IDLE,
    ST_BUILD,   // stream weights into prefix sums
    ST_MUL,     // target = floor(u * total / 2^32)
    ST_PROBE,   // first bisection read
    ST_SEARCH   // one compare and one read per cycle
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            cnt;
  logic [dcs_pkg::COUNT_W-1:0] entries;
  logic                        stale;
  logic [CUM_W-1:0]            sum;
  logic [CUM_W-1:0]            total;
  logic [dcs_pkg::FRAC_W-1:0]  frac;
  logic [KW-1:0]               chunk;
  logic [PROD_W-1:0]           acc;
  logic [IDX_W-1:0]            lo;     // lowest candidate (bisection lo + 1)
  logic [IDX_W-1:0]            hi;
  logic [IDX_W-1:0]            mid;

  // the two memories
  logic [WEIGHT_BITS-1:0] wmem [TABLE_DEPTH];
  logic [CUM_W-1:0]       cmem [TABLE_DEPTH];

  logic                   w_we, w_re;
  logic [IDX_W-1:0]       w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rd;
  logic                   c_we, c_re;
  logic [IDX_W-1:0]       c_waddr, c_raddr;
  logic [CUM_W-1:0]       c_wdata, c_rd;

  logic                   accept;
  logic                   in_range;
  logic [IDX_W-1:0]       nlast;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(entry_index) < TABLE_DEPTH);

  // last index in use, with zero acting as one and overflow clamped
  always_comb begin
    if (entries == '0) begin
      nlast = '0;
    end else if (32'(entries) > TABLE_DEPTH) begin
      nlast = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      nlast = IDX_W'(entries - dcs_pkg::COUNT_W'(1));
    end
  end

  // weight memory: clearing pass or command write, streaming read during rebuild
  always_comb begin
    if (state == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = cnt[IDX_W-1:0];
      w_wdata = '0;
    end else begin
      w_we    = accept && (operation == dcs_pkg::OP_WRITE) && in_range;
      w_waddr = IDX_W'(entry_index);
      w_wdata = WEIGHT_BITS'(weight);
    end
  end

  assign w_re    = (state == ST_BUILD) && (cnt <= {1'b0, nlast});
  assign w_raddr = cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (w_re) begin
      w_rd <= wmem[w_raddr];
    end
  end

  // rebuild: the weight read in the previous cycle is summed and written back
  logic [CUM_W-1:0] sum_new;
  logic [CNT_W-1:0] wr_idx;
  logic             build_last;

  assign sum_new    = sum + CUM_W'(w_rd);
  assign wr_idx     = cnt - CNT_W'(1);
  assign c_we       = (state == ST_BUILD) && (cnt != '0);
  assign c_waddr    = wr_idx[IDX_W-1:0];
  assign c_wdata    = sum_new;
  assign build_last = c_we && (wr_idx == {1'b0, nlast});

  // target multiply, one 32x16 partial product per cycle
  logic [TOT_PAD-1:0]             tot_pad;
  logic [15:0]                    part;
  logic [dcs_pkg::FRAC_W+15:0]    prod;
  logic [PROD_W-1:0]              acc_next;

  assign tot_pad  = TOT_PAD'(total);
  assign part     = tot_pad[16*chunk +: 16];
  assign prod     = frac * part;
  assign acc_next = acc + (PROD_W'(prod) << {chunk, 4'b0000});

  // bisection step
  logic [CUM_W-1:0] target;
  logic             greater;
  logic [IDX_W-1:0] cur_lo, cur_hi, mid_next;
  logic [CNT_W-1:0] span, mid_w;
  logic             more;

  assign target  = acc[dcs_pkg::FRAC_W +: CUM_W];
  assign greater = target > c_rd;

  always_comb begin
    if (state == ST_SEARCH) begin
      cur_lo = greater ? (mid + 1'b1) : lo;
      cur_hi = greater ? hi : mid;
    end else begin
      cur_lo = lo;
      cur_hi = hi;
    end
  end

  assign more     = cur_hi > cur_lo;
  assign span     = {1'b0, cur_hi} - {1'b0, cur_lo} + CNT_W'(1);
  assign mid_w    = {1'b0, cur_lo} + (span >> 1) - CNT_W'(1);
  assign mid_next = mid_w[IDX_W-1:0];
  assign c_re     = (state inside {ST_PROBE, ST_SEARCH}) && more;
  assign c_raddr  = mid_next;

  // prefix-sum memory: written during rebuild, read during search
  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rd <= cmem[c_raddr];
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= '0;
      entries <= dcs_pkg::COUNT_RESET;
      stale   <= 1'b1;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      // config changes the set of entries, so the sums go stale
      if (cfg_write) begin
        entries <= entries_in_use;
        stale   <= 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (operation == dcs_pkg::OP_WRITE) begin
              if (in_range) begin
                stale <= 1'b1;
              end
            end else begin
              frac  <= random_fraction;
              lo    <= '0;
              hi    <= nlast;
              acc   <= '0;
              chunk <= '0;
              cnt   <= '0;
              sum   <= '0;
              state <= stale ? ST_BUILD : ST_MUL;
            end
          end
        end
        ST_BUILD: begin
          cnt <= cnt + CNT_W'(1);
          if (c_we) begin
            sum <= sum_new;
          end
          if (build_last) begin
            total <= sum_new;
            stale <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc   <= acc_next;
          chunk <= chunk + 1'b1;
          if (chunk == KW'(CHUNKS - 1)) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE, ST_SEARCH: begin
          lo  <= cur_lo;
          hi  <= cur_hi;
          mid <= mid_next;
          if (more) begin
            state <= ST_SEARCH;
          end else begin
            done          <= 1'b1;
            sampled_index <= dcs_pkg::RESULT_W'(cur_hi);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/dcs_checker.sv @@
// port-level checks for the discrete cdf sampler, bound to the top level
`default_nettype none

module dcs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic operation,
  input wire logic done
);

  // reset starts the clearing pass
  assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a weight write leaves the block idle and gives no result
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == dcs_pkg::OP_WRITE) |=> (!busy && !done))
    else $error("weight write caused busy or result");

  // a sample keeps the block busy and gives no result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == dcs_pkg::OP_SAMPLE) |=> (busy && !done))
    else $error("sample not taken up");

  // a result ends the work on a sample
  assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result outside a sample");

endmodule

bind discrete_cdf_sampler dcs_checker u_dcs_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done)
);

`default_nettype wire

@@ test/discrete_cdf_sampler_tb.sv @@
// self-checking testbench for the discrete cdf sampler: weight writes, draws and count changes
`timescale 1ns / 1ps

module discrete_cdf_sampler_tb;
  import dcs_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;

  // tracks the weight table and prefix sums and queues the index each draw must return
  class draw_tracker;
    logic [WEIGHT_W-1:0] weights [DEPTH];
    logic [23:0]         prefix [DEPTH];
    bit                  sums_stale;
    logic [COUNT_W-1:0]  count_reg;
    logic [RESULT_W-1:0] pending_draws [$];
    int                  errors;

    function new();
      foreach (weights[i]) begin
        weights[i] = '0;
        prefix[i] = '0;
      end
      sums_stale = 1'b1;
      count_reg = COUNT_RESET;
      errors = 0;
    endfunction

    function int active_count();
      if (count_reg == 0) return 1;
      if (count_reg > DEPTH) return DEPTH;
      return int'(count_reg);
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      count_reg = value;
      sums_stale = 1'b1;
    endfunction

    function logic [RESULT_W-1:0] predict_draw(logic [FRAC_W-1:0] u);
      int          n;
      int          lo;
      int          hi;
      int          mid;
      logic [23:0] sum;
      logic [63:0] target;
      n = active_count();
      if (sums_stale) begin
        sum = '0;
        for (int i = 0; i < n; i++) begin
          sum = sum + 24'(weights[i]);
          prefix[i] = sum;
        end
        sums_stale = 1'b0;
      end
      // floor(u * total / 2^32): the product fits in 56 bits
      target = (64'(u) * 64'(prefix[n-1])) >> 32;
      lo = -1;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (target > 64'(prefix[mid])) lo = mid;
        else hi = mid;
      end
      return RESULT_W'(hi);
    endfunction

    function void note_command(logic op, logic [ENTRY_W-1:0] idx, logic [WEIGHT_W-1:0] w,
                               logic [FRAC_W-1:0] u);
      if (op == OP_WRITE) begin
        weights[idx] = w;
        sums_stale = 1'b1;
      end else begin
        pending_draws.push_back(predict_draw(u));
      end
    endfunction

    function int pending_size();
      return pending_draws.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_draw(logic [RESULT_W-1:0] got);
      logic [RESULT_W-1:0] want;
      if (pending_draws.size() == 0) begin
        report($sformatf("sampled_index %0d with no draw outstanding", got));
      end else begin
        want = pending_draws.pop_front();
        if (got !== want)
          report($sformatf("sampled_index %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                operation;
  logic [ENTRY_W-1:0]  entry_index;
  logic [WEIGHT_W-1:0] weight;
  logic [FRAC_W-1:0]   random_fraction;
  logic                done;
  logic [RESULT_W-1:0] sampled_index;
  logic                cfg_write;
  logic [COUNT_W-1:0]  entries_in_use;

  draw_tracker sb;
  int          n_eff;   // entries in use as the block applies them, for shaping stimulus

  discrete_cdf_sampler u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .entry_index     (entry_index),
    .weight          (weight),
    .random_fraction (random_fraction),
    .done            (done),
    .sampled_index   (sampled_index),
    .cfg_write       (cfg_write),
    .entries_in_use  (entries_in_use)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs; a correct run needs well under a tenth of this
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // results cannot be held off, so every done strobe is a finished transaction
  always @(posedge clk) begin
    if (!rst && done) sb.check_draw(sampled_index);
  end

  // one command transaction: drive at the falling edge, hold until an edge sees busy low
  task automatic send_command(input logic op, input logic [ENTRY_W-1:0] idx,
                              input logic [WEIGHT_W-1:0] w, input logic [FRAC_W-1:0] u);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    entry_index = idx;
    weight = w;
    random_fraction = u;
    do @(posedge clk); while (busy);
    sb.note_command(op, idx, w, u);
  endtask

  // sender gaps: start low with junk on the payload, pct chance per cycle of another gap
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start = 1'b0;
      operation = 1'($urandom);
      entry_index = ENTRY_W'($urandom);
      weight = WEIGHT_W'($urandom);
      random_fraction = $urandom;
    end
  endtask

  // drop start and wait for every outstanding draw, then let a trailing write settle
  task automatic wait_quiet(input int settle);
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    cfg_write = 1'b1;
    entries_in_use = value;
    @(posedge clk);
    sb.set_count(value);
    @(negedge clk);
    cfg_write = 1'b0;
    n_eff = sb.active_count();
  endtask

  // one random command, mostly writes inside the active range and draws over it
  task automatic random_command(input int pct);
    logic                op;
    logic [ENTRY_W-1:0]  idx;
    logic [WEIGHT_W-1:0] w;
    logic [FRAC_W-1:0]   u;
    int                  pick;
    op = ($urandom_range(99) < 55) ? OP_SAMPLE : OP_WRITE;
    idx = ($urandom_range(99) < 85) ? ENTRY_W'($urandom_range(n_eff - 1))
                                    : ENTRY_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) w = '0;
    else if (pick < 25) w = '1;
    else if (pick < 35) w = WEIGHT_W'($urandom_range(3));
    else w = WEIGHT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) u = '0;
    else if (pick < 10) u = '1;
    else u = $urandom;
    idle_gap(pct);
    send_command(op, idx, w, u);
  endtask

  logic [COUNT_W-1:0] fixed_counts [7] = '{9'd256, 9'd0, 9'd2, 9'd511, 9'd1, 9'd257, 9'd3};

  initial begin
    int                 pct;
    logic [COUNT_W-1:0] count_value;
    sb = new();
    n_eff = DEPTH;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_WRITE;
    entry_index = '0;
    weight = '0;
    random_fraction = '0;
    cfg_write = 1'b0;
    entries_in_use = COUNT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // the clearing pass after reset keeps busy high; send_command waits it out

    // directed: all-zero table first, then extreme weights and fractions
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'hFFFF_FFFF);  // all weights zero
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h0000_0000);
    send_command(OP_WRITE,  8'd0,   16'hFFFF, 32'h0000_0000);
    send_command(OP_WRITE,  8'd255, 16'hFFFF, 32'h0000_0000);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h0000_0000);  // zero target
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'hFFFF_FFFF);  // top of the range
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h8000_0000);
    send_command(OP_WRITE,  8'd0,   16'h0000, 32'h0000_0000);  // lowest entry weightless
    send_command(OP_WRITE,  8'd128, 16'h8000, 32'h0000_0000);
    send_command(OP_WRITE,  8'd1,   16'h0001, 32'h0000_0000);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h0000_0000);  // zero target hits entry 0
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h0000_0001);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h7FFF_FFFF);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'hFFFF_FFFF);
    send_command(OP_WRITE,  8'd85,  16'h5555, 32'h0000_0000);
    send_command(OP_WRITE,  8'd170, 16'hAAAA, 32'h0000_0000);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'h5555_5555);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'hAAAA_AAAA);
    send_command(OP_SAMPLE, 8'd0,   16'h0000, 32'hC000_0000);

    // random segments, each with its own entry count; light sender gaps, then heavy, then none
    for (int seg = 0; seg < 11; seg++) begin
      wait_quiet(16);
      count_value = (seg < 7) ? fixed_counts[seg] : COUNT_W'($urandom_range(255, 4));
      write_count(count_value);
      pct = (seg < 4) ? 9 : (seg < 8) ? 87 : 0;
      for (int k = 0; k < 100; k++) begin
        // now and then hold off until every draw has come back
        if ($urandom_range(59) == 0) wait_quiet(0);
        random_command(pct);
      end
    end

    wait_quiet(40);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
